@@ sv/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the sparse polynomial adder
// Operation codes, sequencer states, stored term layout and bus widths.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned MaxTermsDef = 32;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned ExpW        = 16;
  localparam int unsigned SumCoefW    = CoefW + 1;
  localparam int unsigned TermW       = CoefW + ExpW;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 40;
  localparam int unsigned OpW         = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_FIRST  = 2'd0,
    OP_INS_SECOND = 2'd1,
    OP_ADD        = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_MRG
  } state_e;

  typedef struct packed {
    logic        [ExpW-1:0]  expn;
    logic signed [CoefW-1:0] coef;
  } term_t;

endpackage

@@ sv/sparse_polynomial_adder_top.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_top: adder of two sparse polynomials
// Keeps two term lists sorted by descending exponent and merges them on an
// add command, emitting the sum terms highest exponent first.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents (lowest bit up)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tuser: operation; tdata: term_coef, term_exp
//  m_axis    out  tdata: sum_coef, sum_exp, pad; tlast: last_term;
//                 tuser: sum_empty, overflow_seen
//
//  An insert into an empty list writes the head directly and one into a full
//  list is dropped; otherwise it shifts each stored entry with a lower
//  exponent up one slot (at most MAX_TERMS - 1 entries), one RAM read and
//  one write per cycle. An add merges both lists step by step, one entry
//  of each list read per cycle through the shared exponent compare.
//  A stalled m_axis beat holds the merge; s_axis is not ready until an item
//  is done. Reset clears both counts and the overflow flag; list RAMs need
//  no clearing since only entries below the count are read.
//
module sparse_polynomial_adder_top
  import spa_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MaxTermsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // term_coef[15:0], term_exp[31:16]
  input  logic [OpW-1:0]      s_axis_tuser,   // operation[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // sum_coef[16:0], sum_exp[32:17], zero pad
  output logic                m_axis_tlast,   // last_term
  output logic [1:0]          m_axis_tuser    // sum_empty[0], overflow_seen[1]
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_TERMS);

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CW-1:0]         n1_q, n1_d, n2_q, n2_d;
  logic [CW-1:0]         a_q, a_d, c_q, c_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  ovf_q, ovf_d;
  logic                  sel_q, sel_d;
  term_t                 term_q, term_d;

  logic                  pend_valid_q, pend_valid_d;
  logic [SumCoefW-1:0]   pend_coef_q, pend_coef_d;
  logic [ExpW-1:0]       pend_exp_q, pend_exp_d;

  logic                  out_valid_q, out_valid_d;
  logic [SumCoefW-1:0]   out_coef_q, out_coef_d;
  logic [ExpW-1:0]       out_exp_q, out_exp_d;
  logic                  out_last_q, out_last_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_ovf_q, out_ovf_d;

  // --------------------------------------------------------------------------
  // List RAMs
  // --------------------------------------------------------------------------
  logic                  we1, we2;
  logic [AW-1:0]         waddr, raddr1, raddr2;
  term_t                 wdata;
  logic [TermW-1:0]      rdata1_raw, rdata2_raw;
  term_t                 rd1, rd2;

  spa_ram #(.WIDTH(TermW), .DEPTH(MAX_TERMS)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr1),
    .rdata_o (rdata1_raw)
  );

  spa_ram #(.WIDTH(TermW), .DEPTH(MAX_TERMS)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr2),
    .rdata_o (rdata2_raw)
  );

  assign rd1 = term_t'(rdata1_raw);
  assign rd2 = term_t'(rdata2_raw);

  // --------------------------------------------------------------------------
  // Shared exponent compare: stored entry vs new term while inserting,
  // first list head vs second list head while merging
  // --------------------------------------------------------------------------
  logic [ExpW-1:0]       cmp_lhs, cmp_rhs;
  logic                  cmp_lt, cmp_gt;
  term_t                 rd_sel;

  assign rd_sel  = sel_q ? rd2 : rd1;
  assign cmp_lhs = (state_q == S_MRG) ? rd1.expn : rd_sel.expn;
  assign cmp_rhs = (state_q == S_MRG) ? rd2.expn : term_q.expn;
  assign cmp_lt  = cmp_lhs < cmp_rhs;
  assign cmp_gt  = cmp_lhs > cmp_rhs;

  // Coefficient adder for equal exponents
  logic [SumCoefW-1:0]   coef1_x, coef2_x, coef_sum;
  assign coef1_x  = {rd1.coef[CoefW-1], rd1.coef};
  assign coef2_x  = {rd2.coef[CoefW-1], rd2.coef};
  assign coef_sum = coef1_x + coef2_x;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic                  in_beat, out_slot_free;
  logic                  in_sel;
  logic [CW-1:0]         in_cnt;
  term_t                 in_term;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_sel        = s_axis_tuser[0];
  assign in_cnt        = in_sel ? n2_q : n1_q;
  assign in_term.coef  = s_axis_tdata[CoefW-1:0];
  assign in_term.expn  = s_axis_tdata[CoefW +: ExpW];
  assign out_slot_free = !out_valid_q || m_axis_tready;

  logic                  a_has, c_has;
  assign a_has = a_q < n1_q;
  assign c_has = c_q < n2_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    logic                take_first, take_second, keep;
    logic [SumCoefW-1:0] res_coef;
    logic [ExpW-1:0]     res_exp;
    logic [AW-1:0]       ins_raddr;

    state_d      = state_q;
    n1_d         = n1_q;
    n2_d         = n2_q;
    a_d          = a_q;
    c_d          = c_q;
    idx_d        = idx_q;
    ovf_d        = ovf_q;
    sel_d        = sel_q;
    term_d       = term_q;
    pend_valid_d = pend_valid_q;
    pend_coef_d  = pend_coef_q;
    pend_exp_d   = pend_exp_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_coef_d   = out_coef_q;
    out_exp_d    = out_exp_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_ovf_d    = out_ovf_q;

    we1          = 1'b0;
    we2          = 1'b0;
    waddr        = idx_q;
    wdata        = term_q;
    ins_raddr    = idx_q - AW'(2);

    take_first   = !c_has || (a_has && cmp_gt);
    take_second  = !take_first && (!a_has || cmp_lt);
    keep         = 1'b1;
    res_coef     = coef_sum;
    res_exp      = rd1.expn;

    case (state_q)
      S_IDLE: begin
        ins_raddr = in_cnt[AW-1:0] - AW'(1);
        if (in_beat) begin
          case (s_axis_tuser)
            OP_INS_FIRST, OP_INS_SECOND: begin
              sel_d  = in_sel;
              term_d = in_term;
              if (in_cnt == CntMax) begin
                // drop the term, remember it
                ovf_d = 1'b1;
              end else begin
                if (in_sel) n2_d = in_cnt + CW'(1);
                else        n1_d = in_cnt + CW'(1);
                if (in_cnt == '0) begin
                  // empty list: place directly at the head
                  waddr = '0;
                  wdata = in_term;
                  we1   = !in_sel;
                  we2   = in_sel;
                end else begin
                  idx_d   = in_cnt[AW-1:0];
                  state_d = S_INS;
                end
              end
            end
            OP_ADD: begin
              a_d          = '0;
              c_d          = '0;
              pend_valid_d = 1'b0;
              state_d      = S_MRG;
            end
            default: ;
          endcase
        end
      end

      S_INS: begin
        // rd_sel holds the entry just below idx_q
        we1 = !sel_q;
        we2 = sel_q;
        if (cmp_lt) begin
          // shift the entry up one slot, advance down
          wdata = rd_sel;
          idx_d = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            state_d = S_INS_PUT;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      S_INS_PUT: begin
        we1     = !sel_q;
        we2     = sel_q;
        state_d = S_IDLE;
      end

      S_MRG: begin
        if (out_slot_free) begin
          if (!a_has && !c_has) begin
            // flush the held term as last, or report an empty sum
            out_valid_d  = 1'b1;
            out_last_d   = 1'b1;
            out_ovf_d    = ovf_q;
            out_empty_d  = !pend_valid_q;
            out_coef_d   = pend_valid_q ? pend_coef_q : '0;
            out_exp_d    = pend_valid_q ? pend_exp_q : '0;
            pend_valid_d = 1'b0;
            n1_d         = '0;
            n2_d         = '0;
            ovf_d        = 1'b0;
            state_d      = S_IDLE;
          end else begin
            if (take_first) begin
              res_coef = coef1_x;
              res_exp  = rd1.expn;
              a_d      = a_q + CW'(1);
            end else if (take_second) begin
              res_coef = coef2_x;
              res_exp  = rd2.expn;
              c_d      = c_q + CW'(1);
            end else begin
              keep = (coef_sum != '0);
              a_d  = a_q + CW'(1);
              c_d  = c_q + CW'(1);
            end
            if (keep) begin
              // hold the new term until the next one shows it is not last
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_last_d  = 1'b0;
                out_empty_d = 1'b0;
                out_ovf_d   = ovf_q;
                out_coef_d  = pend_coef_q;
                out_exp_d   = pend_exp_q;
              end
              pend_valid_d = 1'b1;
              pend_coef_d  = res_coef;
              pend_exp_d   = res_exp;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    // read ports: merge reads at the next pointers, insert walks down
    if (state_q == S_MRG || (state_q == S_IDLE && state_d == S_MRG)) begin
      raddr1 = a_d[AW-1:0];
      raddr2 = c_d[AW-1:0];
    end else begin
      raddr1 = ins_raddr;
      raddr2 = ins_raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n1_q         <= '0;
      n2_q         <= '0;
      a_q          <= '0;
      c_q          <= '0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      n1_q         <= n1_d;
      n2_q         <= n2_d;
      a_q          <= a_d;
      c_q          <= c_d;
      idx_q        <= idx_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    term_q      <= term_d;
    pend_coef_q <= pend_coef_d;
    pend_exp_q  <= pend_exp_d;
    out_coef_q  <= out_coef_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  // --------------------------------------------------------------------------
  // Output beat
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - SumCoefW - ExpW)'(0), out_exp_q, out_coef_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_ovf_q, out_empty_q};

endmodule

@@ sv/spa_ram.sv @@
// ----------------------------------------------------------------------------
// spa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/spa_checker.sv @@
// ----------------------------------------------------------------------------
// spa_checker: port-level checks of the sparse polynomial adder
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module spa_checker
  import spa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [OpW-1:0]      s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic [1:0]          m_axis_tuser
);

  // an empty-sum beat is the only beat of its add and carries no term
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty sum beat without last marker or with nonzero data");

  // an accepted add keeps the input side busy in the next cycle
  a_add_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ADD) |=> !s_axis_tready)
    else $error("input ready right after an add beat");

  // the pad bits of a result beat stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:SumCoefW+ExpW] == '0))
    else $error("nonzero pad bits in result beat");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule

bind sparse_polynomial_adder_top spa_checker u_spa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ test/sparse_polynomial_adder_checker.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_checker: scoreboard of the sparse polynomial adder
// Watches both stream channels, keeps its own copy of the two term lists and
// compares every result beat against the predicted sum terms.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder_checker
  import spa_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // term_coef[15:0], term_exp[31:16]
  input  logic [OpW-1:0]      s_axis_tuser,   // operation[1:0]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // sum_coef[16:0], sum_exp[32:17], zero pad
  input  logic                m_axis_tlast,   // last_term
  input  logic [1:0]          m_axis_tuser,   // sum_empty[0], overflow_seen[1]
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  typedef struct {
    logic signed [SumCoefW-1:0] coef;
    logic        [ExpW-1:0]     expn;
    logic                       last_term;
    logic                       sum_empty;
    logic                       overflow_seen;
  } sum_term_t;

  term_t       first_list [MaxTerms];
  term_t       second_list[MaxTerms];
  int unsigned first_cnt;
  int unsigned second_cnt;
  logic        dropped_flag;
  sum_term_t   expected_sums[$];
  int unsigned mismatch_count;

  // Sorted insert behind equal exponents; a full list drops the term.
  function automatic void place_term(input bit to_second, input term_t t);
    term_t       lst[MaxTerms];
    int unsigned n;
    int unsigned pos;
    int unsigned i;
    if (to_second) begin
      lst = second_list;
      n   = second_cnt;
    end else begin
      lst = first_list;
      n   = first_cnt;
    end
    if (n >= MaxTerms) begin
      dropped_flag = 1'b1;
      return;
    end
    pos = 0;
    while (pos < n && lst[pos].expn >= t.expn) pos++;
    for (i = n; i > pos; i--) lst[i] = lst[i-1];
    lst[pos] = t;
    if (to_second) begin
      second_list = lst;
      second_cnt  = n + 1;
    end else begin
      first_list = lst;
      first_cnt  = n + 1;
    end
  endfunction

  // Merge both lists by exponent, queue the sum beats, then clear.
  function automatic void predict_sum();
    sum_term_t                  run[2*MaxTerms];
    int unsigned                a;
    int unsigned                c;
    int unsigned                k;
    int unsigned                i;
    logic signed [SumCoefW-1:0] sc;
    logic        [ExpW-1:0]     se;
    bit                         keep;
    a = 0;
    c = 0;
    k = 0;
    while (a < first_cnt || c < second_cnt) begin
      keep = 1'b1;
      if (c >= second_cnt || (a < first_cnt && first_list[a].expn > second_list[c].expn)) begin
        sc = $signed(first_list[a].coef);
        se = first_list[a].expn;
        a++;
      end else if (a >= first_cnt || first_list[a].expn < second_list[c].expn) begin
        sc = $signed(second_list[c].coef);
        se = second_list[c].expn;
        c++;
      end else begin
        sc = $signed(first_list[a].coef) + $signed(second_list[c].coef);
        se = first_list[a].expn;
        a++;
        c++;
        keep = (sc != 0);
      end
      if (keep) begin
        run[k] = '{coef: sc, expn: se, last_term: 1'b0, sum_empty: 1'b0,
                   overflow_seen: dropped_flag};
        k++;
      end
    end
    if (k == 0) begin
      expected_sums.push_back('{coef: '0, expn: '0, last_term: 1'b1, sum_empty: 1'b1,
                                overflow_seen: dropped_flag});
    end else begin
      for (i = 0; i < k; i++) begin
        if (i == k - 1) run[i].last_term = 1'b1;
        expected_sums.push_back(run[i]);
      end
    end
    first_cnt    = 0;
    second_cnt   = 0;
    dropped_flag = 1'b0;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sum_term_t want;
    term_t     t;
    if (!rst_ni) begin
      first_cnt      = 0;
      second_cnt     = 0;
      dropped_flag   = 1'b0;
      mismatch_count = 0;
      expected_sums.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare results first: a new add never produces a beat in its own cycle.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: result beat mismatch, expected no beat, actual coef %0d exp %0d",
                   $time, $signed(m_axis_tdata[SumCoefW-1:0]),
                   m_axis_tdata[SumCoefW +: ExpW]);
          mismatch_count++;
        end else begin
          want = expected_sums.pop_front();
          check_field("sum_coef", want.coef, $signed(m_axis_tdata[SumCoefW-1:0]));
          check_field("sum_exp", want.expn, m_axis_tdata[SumCoefW +: ExpW]);
          check_field("last_term", want.last_term, m_axis_tlast);
          check_field("sum_empty", want.sum_empty, m_axis_tuser[0]);
          check_field("overflow_seen", want.overflow_seen, m_axis_tuser[1]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        t.coef = s_axis_tdata[CoefW-1:0];
        t.expn = s_axis_tdata[CoefW +: ExpW];
        case (s_axis_tuser)
          OP_INS_FIRST:  place_term(1'b0, t);
          OP_INS_SECOND: place_term(1'b1, t);
          OP_ADD:        predict_sum();
          default: ;
        endcase
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_sums.size();
    end
  end

endmodule

@@ test/tb_sparse_polynomial_adder_top.sv @@
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_adder_top: stream test of the sparse polynomial adder
// Drives directed and random term loads and add commands with bursty input
// and a stalling output; the checker module scores every result beat.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_adder_top;
  import spa_pkg::*;

  localparam int unsigned ItemsTarget   = 130;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 80;
  // Operation code outside the defined set; the block must ignore it.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef enum logic [1:0] {
    SEQ_MIXED,
    SEQ_CANCEL,
    SEQ_FILL
  } seq_kind_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending_sums;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode     = RX_OPEN;
  logic [5:0]  rx_phase    = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sparse_polynomial_adder_top #(
    .MAX_TERMS(MaxTermsDef)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  sparse_polynomial_adder_checker #(
    .MaxTerms(MaxTermsDef)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .pending_o     (pending_sums)
  );

  // Output backpressure: switch the stall pattern each time the 6-bit phase counter wraps, so that
  // fully open stretches alternate with coin-flip, sparse and periodic stalls.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 6'd1;
    if (rx_phase == '0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: m_axis_tready <= (rx_phase[2:0] == 3'd5);
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one beat and hold it until accepted. Open a random gap whenever
  // the current burst runs out; bursts are mostly short, sometimes long.
  task automatic put_beat(input logic [OpW-1:0] op, input logic [CoefW-1:0] coef,
                          input logic [ExpW-1:0] expn);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {expn, coef};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (op != OpUnused) items_sent++;
  endtask

  // Bias coefficients toward the extremes and small values.
  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(1, 5));
      default: return 16'($urandom);
    endcase
  endfunction

  // Draw exponents mostly from a small pool so that terms collide often.
  function automatic logic [ExpW-1:0] pick_exp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 7) == 0) put_beat(OpUnused, 16'($urandom), 16'($urandom));
  endtask

  // Load one pair of polynomials of the given shape and add them.
  task automatic run_sequence(input seq_kind_e kind);
    int unsigned     n;
    logic            side;
    logic [CoefW-1:0] x;
    logic [ExpW-1:0]  e;
    maybe_noise();
    case (kind)
      SEQ_MIXED: begin
        n = $urandom_range(0, 8);
        repeat (n) begin
          maybe_noise();
          put_beat($urandom_range(0, 1) ? OP_INS_SECOND : OP_INS_FIRST, pick_coef(),
                   pick_exp());
        end
      end
      SEQ_CANCEL: begin
        // Load opposite coefficients at equal exponents; add a stray term now and then.
        n = $urandom_range(1, 5);
        repeat (n) begin
          x = pick_coef();
          if (x == 16'h8000) x = 16'h0001;
          e = pick_exp();
          put_beat(OP_INS_FIRST, x, e);
          put_beat(OP_INS_SECOND, -x, e);
        end
        if ($urandom_range(0, 1)) put_beat(OP_INS_SECOND, pick_coef(), pick_exp());
      end
      SEQ_FILL: begin
        // Overfill one list so the drop flag rides on the sum.
        side = 1'($urandom_range(0, 1));
        n    = MaxTermsDef + $urandom_range(1, 3);
        repeat (n) put_beat(side ? OP_INS_SECOND : OP_INS_FIRST, pick_coef(), pick_exp());
        repeat ($urandom_range(0, 4)) begin
          put_beat(side ? OP_INS_FIRST : OP_INS_SECOND, pick_coef(), pick_exp());
        end
      end
      default: ;
    endcase
    put_beat(OP_ADD, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    seq_kind_e kind;
    int unsigned draw;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Add with both lists empty: expect a single empty-sum beat.
    put_beat(OP_ADD, 16'hFFFF, 16'hFFFF);

    // Extremes of both fields, equal exponents inside one list, a sum that
    // cancels to zero and an unused operation code in between.
    put_beat(OP_INS_FIRST,  16'h7FFF, 16'hFFFF);
    put_beat(OP_INS_FIRST,  16'h8000, 16'h0000);
    put_beat(OP_INS_FIRST,  16'h0007, 16'd300);
    put_beat(OP_INS_FIRST,  16'h0009, 16'd300);
    put_beat(OP_INS_SECOND, 16'h7FFF, 16'hFFFF);
    put_beat(OP_INS_SECOND, 16'h8000, 16'h0000);
    put_beat(OP_INS_SECOND, -16'sd7,  16'd300);
    put_beat(OpUnused,      16'h5555, 16'hAAAA);
    put_beat(OP_INS_SECOND, 16'h0005, 16'd1000);
    put_beat(OP_ADD,        16'h0000, 16'h0000);

    // Everything cancels: empty sum again.
    put_beat(OP_INS_FIRST,  16'd100,    16'd42);
    put_beat(OP_INS_SECOND, -16'sd100,  16'd42);
    put_beat(OpUnused,      16'hAAAA,   16'h5555);
    put_beat(OP_ADD,        16'h1234,   16'h4321);

    // Second list only, with an equal-exponent pair that has no partner.
    put_beat(OP_INS_SECOND, 16'd1, 16'd5);
    put_beat(OP_INS_SECOND, 16'd2, 16'd5);
    put_beat(OP_INS_SECOND, 16'd3, 16'd9);
    put_beat(OP_ADD,        16'd0, 16'd0);

    // Lowest term cancels: the last marker moves to the term before it.
    put_beat(OP_INS_FIRST,  16'd4,   16'd20);
    put_beat(OP_INS_FIRST,  16'd6,   16'd3);
    put_beat(OP_INS_SECOND, -16'sd6, 16'd3);
    put_beat(OP_ADD,        16'd0,   16'd0);

    // Random part: open with an overfilled list, then mostly short loads.
    run_sequence(SEQ_FILL);
    while (items_sent < ItemsTarget) begin
      draw = $urandom_range(0, 9);
      if (draw == 0) begin
        kind = SEQ_FILL;
      end else if (draw <= 3) begin
        kind = SEQ_CANCEL;
      end else begin
        kind = SEQ_MIXED;
      end
      run_sequence(kind);
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every predicted beat, then let the block settle.
    do @(posedge clk_i); while (pending_sums != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
